@@ hdl/command_completeness_scanner_assert.svh @@
// assertion macros for the command completeness scanner
`ifndef COMMAND_COMPLETENESS_SCANNER_ASSERT_SVH
`define COMMAND_COMPLETENESS_SCANNER_ASSERT_SVH

// antecedent in this cycle implies consequent in the next cycle
`define CCS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ccs next-cycle check failed");

// antecedent implies consequent in the same cycle
`define CCS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ccs same-cycle check failed");

`endif

@@ hdl/ccs_pkg.sv @@
`default_nettype none

package ccs_pkg;

   localparam int DEPTH_BITS = 16;
   localparam int DEPTH_OUT_BITS = 16;

   localparam logic [1:0] STR_NONE    = 2'd0;
   localparam logic [1:0] STR_SINGLE  = 2'd1;
   localparam logic [1:0] STR_DOUBLE  = 2'd2;
   localparam logic [1:0] STR_VERBATIM = 2'd3;

   localparam logic [7:0] CH_AT        = 8'h40;
   localparam logic [7:0] CH_LBRACE    = 8'h7B;
   localparam logic [7:0] CH_RBRACE    = 8'h7D;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_EQUALS    = 8'h3D;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
   } req_type;

   typedef struct packed {
      logic                             command_complete;
      logic                             return_mode;
      logic                             line_ignored;
      logic [1:0]                       open_string_kind;
      logic signed [DEPTH_OUT_BITS-1:0] depth_now;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                   string_kind;
      logic                         skip_next;
      logic                         at_pending;
      logic                         quote_pending;
      logic signed [DEPTH_BITS-1:0] brace_count;
      logic                         command_open;
      logic                         value_mode;
      logic                         line_started;
      logic                         content_seen;
      logic                         last_was_backslash;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      string_kind:        STR_NONE,
      skip_next:          1'b0,
      at_pending:         1'b0,
      quote_pending:      1'b0,
      brace_count:        '0,
      command_open:       1'b0,
      value_mode:         1'b0,
      line_started:       1'b0,
      content_seen:       1'b0,
      last_was_backslash: 1'b0
   };

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
   endfunction

endpackage

`default_nettype wire

@@ hdl/ccs_scan_logic.sv @@
`default_nettype none

module ccs_scan_logic (
   input  wire ccs_pkg::scan_state_type state_cur,
   input  wire ccs_pkg::req_type        item,
   output ccs_pkg::scan_state_type      state_next,
   output ccs_pkg::rsp_type             result
);

   ccs_pkg::scan_state_type s;
   logic [7:0]              c;
   logic                    scan_go;
   logic                    cont;
   logic                    ignored;
   logic                    complete;
   logic [7:0]              delim;
   logic signed [63:0]      depth_wide;

   always_comb begin
      s          = state_cur;
      c          = item.ch;
      scan_go    = 1'b0;
      cont       = 1'b0;
      ignored    = 1'b0;
      complete   = 1'b0;
      delim      = ccs_pkg::CH_DQUOTE;
      depth_wide = '0;
      result     = '0;

      if (!item.line_end) begin
         // leading whitespace and return mode mark
         if (!s.content_seen) begin
            if (!ccs_pkg::is_space(c)) begin
               if (!s.line_started && !s.command_open && c == ccs_pkg::CH_EQUALS) begin
                  s.line_started = 1'b1;
                  s.value_mode   = 1'b1;
               end else begin
                  s.line_started = 1'b1;
                  s.content_seen = 1'b1;
                  scan_go        = 1'b1;
               end
            end
         end else begin
            scan_go = 1'b1;
         end

         if (scan_go) begin
            if (!ccs_pkg::is_space(c)) begin
               s.last_was_backslash = (c == ccs_pkg::CH_BACKSLASH);
            end
            if (s.skip_next) begin
               s.skip_next = 1'b0;
            end else begin
               cont = 1'b1;
               if (s.quote_pending) begin
                  s.quote_pending = 1'b0;
                  if (c == ccs_pkg::CH_DQUOTE) begin
                     cont = 1'b0;
                  end else begin
                     s.string_kind = ccs_pkg::STR_NONE;
                  end
               end else if (s.at_pending) begin
                  s.at_pending = 1'b0;
                  if (c == ccs_pkg::CH_DQUOTE) begin
                     s.string_kind = ccs_pkg::STR_VERBATIM;
                     cont          = 1'b0;
                  end
               end
               if (cont) begin
                  if (s.string_kind == ccs_pkg::STR_VERBATIM) begin
                     if (c == ccs_pkg::CH_DQUOTE) begin
                        s.quote_pending = 1'b1;
                     end
                  end else if (s.string_kind != ccs_pkg::STR_NONE) begin
                     delim = (s.string_kind == ccs_pkg::STR_SINGLE) ?
                             ccs_pkg::CH_SQUOTE : ccs_pkg::CH_DQUOTE;
                     if (c == delim) begin
                        s.string_kind = ccs_pkg::STR_NONE;
                     end else if (c == ccs_pkg::CH_BACKSLASH) begin
                        s.skip_next = 1'b1;
                     end
                  end else begin
                     case (c)
                        ccs_pkg::CH_SQUOTE: s.string_kind = ccs_pkg::STR_SINGLE;
                        ccs_pkg::CH_DQUOTE: s.string_kind = ccs_pkg::STR_DOUBLE;
                        ccs_pkg::CH_AT:     s.at_pending  = 1'b1;
                        ccs_pkg::CH_RBRACE: begin
                           if (s.brace_count > ccs_pkg::DEPTH_MIN) begin
                              s.brace_count = s.brace_count - 1'b1;
                           end
                        end
                        ccs_pkg::CH_LBRACE: begin
                           if (s.brace_count < ccs_pkg::DEPTH_MAX) begin
                              s.brace_count = s.brace_count + 1'b1;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end
      end else begin
         ignored = !s.content_seen;
         if (!ignored) begin
            // a waiting quote at line end closes the verbatim string
            if (s.quote_pending) begin
               s.string_kind = ccs_pkg::STR_NONE;
            end
            complete = (s.brace_count[ccs_pkg::DEPTH_BITS-1] || s.brace_count == '0) &&
                       (s.string_kind != ccs_pkg::STR_VERBATIM) && !s.last_was_backslash;
         end

         depth_wide               = 64'(s.brace_count);
         result.command_complete  = complete;
         result.return_mode       = s.value_mode;
         result.line_ignored      = ignored;
         result.open_string_kind  = s.string_kind;
         result.depth_now         = depth_wide[ccs_pkg::DEPTH_OUT_BITS-1:0];

         s.skip_next          = 1'b0;
         s.at_pending         = 1'b0;
         s.quote_pending      = 1'b0;
         s.line_started       = 1'b0;
         s.content_seen       = 1'b0;
         s.last_was_backslash = 1'b0;
         if (ignored) begin
            if (!s.command_open) begin
               s.value_mode = 1'b0;
            end
         end else if (complete) begin
            s = ccs_pkg::SCAN_RESET;
         end else begin
            s.command_open = 1'b1;
         end
      end

      state_next = s;
   end

endmodule

`default_nettype wire

@@ hdl/command_completeness_scanner.sv @@
// command completeness scanner
// req channel: one transfer per character of a console line (ch), or one
//   transfer with line_end set to close the line. character transfers give
//   no result; each line end gives exactly one rsp transfer.
// rsp channel: command_complete, return_mode, line_ignored, the string kind
//   still open and the brace depth after the line.
// path: a line end passes the input register, then the result register, and
//   waits in the input register while the result register is held.
// throughput: one item per cycle, but a line end waits while rsp is held;
//   the state update is a single combinational pass between the registers.
// stall: while rsp is held by a low rsp_ready, character items keep flowing;
//   a following line end waits in the input register and req_ready drops
//   only when that register is full and cannot move.
// reset: clears all scanner state (depth zero, no string, no command open)
//   and empties both registers; no item is accepted during reset.
`default_nettype none

module command_completeness_scanner (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  wire ccs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output ccs_pkg::rsp_type rsp_payload
);

   `include "command_completeness_scanner_assert.svh"

   ccs_pkg::req_type        req_ff;
   logic                    req_valid_ff;
   logic                    req_valid_in;
   ccs_pkg::scan_state_type state_ff;
   ccs_pkg::scan_state_type state_in;
   ccs_pkg::rsp_type        rsp_ff;
   ccs_pkg::rsp_type        rsp_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   ccs_pkg::scan_state_type scan_next;
   ccs_pkg::rsp_type        scan_result;
   logic                    out_free;
   logic                    advance;
   logic                    out_load;

   ccs_scan_logic u_scan (
      .state_cur  (state_ff),
      .item       (req_ff),
      .state_next (scan_next),
      .result     (scan_result)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      advance      = req_valid_ff && (!req_ff.line_end || out_free);
      out_load     = advance && req_ff.line_end;
      req_ready    = !reset && (!req_valid_ff || advance);
      req_valid_in = req_valid ? 1'b1 : (req_valid_ff && !advance);
      state_in     = advance ? scan_next : state_ff;
      rsp_in       = out_load ? scan_result : rsp_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ccs_pkg::SCAN_RESET;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid_in;
         end else begin
            req_valid_ff <= req_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_payload;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `CCS_ASSERT_NEXT(a_complete_clears,
      out_load && scan_result.command_complete, state_ff == ccs_pkg::SCAN_RESET)
   `CCS_ASSERT_NEXT(a_rsp_from_line_end, !rsp_valid_ff && !out_load, !rsp_valid_ff)
   `CCS_ASSERT_NOW(a_ignored_not_complete,
      rsp_valid_ff && rsp_ff.line_ignored, !rsp_ff.command_complete)
   `CCS_ASSERT_NOW(a_verbatim_not_complete,
      rsp_valid_ff && rsp_ff.open_string_kind == ccs_pkg::STR_VERBATIM,
      !rsp_ff.command_complete)

endmodule

`default_nettype wire

@@ sim/command_completeness_scanner_tb.sv @@
`default_nettype none

module command_completeness_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEMS_PER_PHASE = 380;
   localparam int SETTLE_CYCLES = 10;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   ccs_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   ccs_pkg::rsp_type rsp_payload;

   command_completeness_scanner dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   ccs_pkg::req_type chars_to_send[$];
   ccs_pkg::rsp_type awaited_verdicts[$];
   int      items_queued = 0;
   int      error_count = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      send_idle_table[4] = '{0, 63, 0, 22};
   int      stall_table[4] = '{0, 0, 63, 22};

   // scanner state as predicted
   logic [1:0]                            quote_state;
   bit                                    skip_char;
   bit                                    at_wait;
   bit                                    quote_wait;
   logic signed [ccs_pkg::DEPTH_BITS-1:0] depth_count;
   bit                                    cmd_open;
   bit                                    ret_mode;
   bit                                    line_begun;
   bit                                    text_seen;
   bit                                    trailing_bs;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic bit is_blank(logic [7:0] c);
      return c == ccs_pkg::CH_SPACE || (c >= ccs_pkg::CH_TAB && c <= ccs_pkg::CH_CR);
   endfunction

   function automatic void end_line();
      skip_char = 1'b0;
      at_wait = 1'b0;
      quote_wait = 1'b0;
      line_begun = 1'b0;
      text_seen = 1'b0;
      trailing_bs = 1'b0;
   endfunction

   function automatic void restart_scan();
      quote_state = ccs_pkg::STR_NONE;
      depth_count = '0;
      cmd_open = 1'b0;
      ret_mode = 1'b0;
      end_line();
   endfunction

   function automatic void scan_char(logic [7:0] c);
      if (skip_char) begin
         skip_char = 1'b0;
         return;
      end
      if (quote_wait) begin
         quote_wait = 1'b0;
         if (c == ccs_pkg::CH_DQUOTE) return;
         quote_state = ccs_pkg::STR_NONE;
      end else if (at_wait) begin
         at_wait = 1'b0;
         if (c == ccs_pkg::CH_DQUOTE) begin
            quote_state = ccs_pkg::STR_VERBATIM;
            return;
         end
      end
      if (quote_state == ccs_pkg::STR_VERBATIM) begin
         if (c == ccs_pkg::CH_DQUOTE) quote_wait = 1'b1;
      end else if (quote_state != ccs_pkg::STR_NONE) begin
         if ((quote_state == ccs_pkg::STR_SINGLE && c == ccs_pkg::CH_SQUOTE) ||
             (quote_state == ccs_pkg::STR_DOUBLE && c == ccs_pkg::CH_DQUOTE)) begin
            quote_state = ccs_pkg::STR_NONE;
         end else if (c == ccs_pkg::CH_BACKSLASH) begin
            skip_char = 1'b1;
         end
      end else begin
         case (c)
            ccs_pkg::CH_SQUOTE: quote_state = ccs_pkg::STR_SINGLE;
            ccs_pkg::CH_DQUOTE: quote_state = ccs_pkg::STR_DOUBLE;
            ccs_pkg::CH_AT:     at_wait = 1'b1;
            ccs_pkg::CH_RBRACE: begin
               if (depth_count != ccs_pkg::DEPTH_MIN) depth_count = depth_count - 1'b1;
            end
            ccs_pkg::CH_LBRACE: begin
               if (depth_count != ccs_pkg::DEPTH_MAX) depth_count = depth_count + 1'b1;
            end
            default: ;
         endcase
      end
   endfunction

   // advance the scanner by one accepted transfer, queue the verdict at a line end
   function automatic void predict_verdict(ccs_pkg::req_type t);
      ccs_pkg::rsp_type v;
      bit               ignored;
      bit               done;
      if (!t.line_end) begin
         if (!text_seen) begin
            if (is_blank(t.ch)) return;
            if (!line_begun) begin
               line_begun = 1'b1;
               if (!cmd_open && t.ch == ccs_pkg::CH_EQUALS) begin
                  ret_mode = 1'b1;
                  return;
               end
            end
            text_seen = 1'b1;
         end
         if (!is_blank(t.ch)) trailing_bs = (t.ch == ccs_pkg::CH_BACKSLASH);
         scan_char(t.ch);
         return;
      end
      ignored = !text_seen;
      done = 1'b0;
      if (!ignored) begin
         if (quote_wait) quote_state = ccs_pkg::STR_NONE;
         done = depth_count <= 0 && quote_state != ccs_pkg::STR_VERBATIM && !trailing_bs;
      end
      v.command_complete = done;
      v.return_mode = ret_mode;
      v.line_ignored = ignored;
      v.open_string_kind = quote_state;
      v.depth_now = depth_count;
      awaited_verdicts.insert(awaited_verdicts.size(), v);
      end_line();
      if (ignored) begin
         if (!cmd_open) ret_mode = 1'b0;
      end else if (done) begin
         restart_scan();
      end else begin
         cmd_open = 1'b1;
      end
   endfunction

   function automatic void push_char(logic [7:0] c);
      ccs_pkg::req_type t;
      t.ch = c;
      t.line_end = 1'b0;
      chars_to_send.insert(chars_to_send.size(), t);
      items_queued++;
   endfunction

   function automatic void push_end();
      ccs_pkg::req_type t;
      t.ch = 8'($urandom_range(0, 255));
      t.line_end = 1'b1;
      chars_to_send.insert(chars_to_send.size(), t);
      items_queued++;
   endfunction

   function automatic void push_line(string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
      push_end();
   endfunction

   function automatic logic [7:0] blank_char();
      if ($urandom_range(0, 1)) return ccs_pkg::CH_SPACE;
      return 8'($urandom_range(ccs_pkg::CH_TAB, ccs_pkg::CH_CR));
   endfunction

   function automatic logic [7:0] body_char();
      case ($urandom_range(0, 4))
         0: return ccs_pkg::CH_BACKSLASH;
         1: return ccs_pkg::CH_DQUOTE;
         2: return ccs_pkg::CH_SQUOTE;
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   function automatic void push_token();
      int n;
      n = $urandom_range(0, 3);
      case ($urandom_range(0, 10))
         0, 1: push_char(8'($urandom_range(33, 126)));
         2: push_char(blank_char());
         3: push_char(ccs_pkg::CH_LBRACE);
         4: push_char(ccs_pkg::CH_RBRACE);
         5: begin
            push_char(ccs_pkg::CH_SQUOTE);
            repeat (n) push_char(body_char());
            if ($urandom_range(0, 3) != 0) push_char(ccs_pkg::CH_SQUOTE);
         end
         6: begin
            push_char(ccs_pkg::CH_DQUOTE);
            repeat (n) push_char(body_char());
            if ($urandom_range(0, 3) != 0) push_char(ccs_pkg::CH_DQUOTE);
         end
         7: begin
            push_char(ccs_pkg::CH_AT);
            push_char(ccs_pkg::CH_DQUOTE);
            repeat (n) begin
               if ($urandom_range(0, 2) == 0) begin
                  push_char(ccs_pkg::CH_DQUOTE);
                  push_char(ccs_pkg::CH_DQUOTE);
               end else begin
                  push_char(body_char());
               end
            end
            if ($urandom_range(0, 3) != 0) push_char(ccs_pkg::CH_DQUOTE);
         end
         8: push_char(ccs_pkg::CH_AT);
         9: push_char(ccs_pkg::CH_BACKSLASH);
         default: push_char(ccs_pkg::CH_EQUALS);
      endcase
   endfunction

   function automatic void push_random_line();
      int kind;
      int n;
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
         n = $urandom_range(0, 8);
         repeat (n) push_char(8'($urandom_range(0, 255)));
      end else if (kind < 4) begin
         n = $urandom_range(0, 3);
         repeat (n) push_char(blank_char());
      end else begin
         if ($urandom_range(0, 1)) push_char(blank_char());
         if ($urandom_range(0, 4) == 0) begin
            push_char(ccs_pkg::CH_EQUALS);
            if ($urandom_range(0, 1)) push_char(blank_char());
         end
         n = $urandom_range(1, 8);
         repeat (n) push_token();
         if ($urandom_range(0, 5) == 0) push_char(ccs_pkg::CH_BACKSLASH);
         if ($urandom_range(0, 3) == 0) push_char(blank_char());
      end
      push_end();
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_verdict(req_payload);
         if (!req_valid || req_ready) begin
            if (chars_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= chars_to_send.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      ccs_pkg::rsp_type want;
      rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_verdicts.size() == 0) begin
            $error("rsp transfer with no verdict pending");
            error_count++;
         end else begin
            want = awaited_verdicts.pop_front();
            check_field("command_complete", want.command_complete,
                        rsp_payload.command_complete);
            check_field("return_mode", want.return_mode, rsp_payload.return_mode);
            check_field("line_ignored", want.line_ignored, rsp_payload.line_ignored);
            check_field("open_string_kind", want.open_string_kind,
                        rsp_payload.open_string_kind);
            check_field("depth_now", $signed(want.depth_now),
                        $signed(rsp_payload.depth_now));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      restart_scan();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // return mode, multi-line braces, blank and mark-only lines
      push_line("= {");
      push_line("}");
      push_line(" \t");
      push_line("=");
      // verbatim with doubled quote, closed by a quote left waiting at line end
      push_line("@\"a\"\"");
      push_line("\"");
      // escapes inside quotes and a trailing backslash
      push_line("'\\'");
      push_line("\"\\");
      push_line("@ }");
      push_char(8'hFF);
      push_char(8'h00);
      push_end();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_idle_table[phase];
         stall_pct = stall_table[phase];
         items_queued = 0;
         while (items_queued < ITEMS_PER_PHASE) push_random_line();
         while (chars_to_send.size() != 0 || req_valid || awaited_verdicts.size() != 0)
            @(negedge clock);
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0 && awaited_verdicts.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ command_completeness_scanner.f @@
+incdir+hdl
hdl/ccs_pkg.sv
hdl/ccs_scan_logic.sv
hdl/command_completeness_scanner.sv
sim/command_completeness_scanner_tb.sv
